>>> sv/cbba_pkg.sv
// shared widths, codes and types of the contiguous block bitmap allocator
package cbba_pkg;

   localparam int CMD_W      = 2;
   localparam int START_W    = 10;
   localparam int SIZE_W     = 26;
   localparam int BSIZE_W    = 16;
   localparam int COUNT_W    = 11;
   localparam int STATUS_W   = 2;
   localparam int IDX_W      = 11;
   localparam int POS_W      = 27;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = 5;
   localparam int MAX_LIMIT  = 2047;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - (STATUS_W + START_W + COUNT_W);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TRUNCATE = 2'd2;

   localparam logic [STATUS_W-1:0] RSP_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_COMPACT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] blocks;
   } div_res_type;

endpackage

>>> sv/contiguous_block_bitmap_allocator.sv
// top level: used/free bitmap of storage blocks in a word memory with a sequencer
//
// Requests come on req_* (tvalid/tready/tdata) and each gives one response on rsp_*.
// Commands: create takes the lowest free block, delete frees a file's run, truncate
// frees trailing blocks or claims the free blocks right after the file.
// The bitmap sits in a memory of 32-bit words; each word touched takes a registered
// read, then a modify and write back. Sizes become block counts in an iterative
// divider, once for delete, twice for truncate. A growing truncate passes its words
// twice (check then set). At the default 1024 blocks a full scan is 32 words.
// One request is in work at a time; req_tready is high while the block is idle.
// A finished response sits in an output register, so the next request is taken
// while the response waits; a new result waits until rsp is free.
// Reset clears the bitmap by a sweep of one word per cycle over
// ceil(min(MAX_BLOCKS, 2047) / 32) words (32 at the default), before req_tready rises.
// Configuration writes through csr_* take effect at once and belong to idle periods.
module contiguous_block_bitmap_allocator
   import cbba_pkg::*;
#(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cmd[1:0], start_block[11:2], current_size[37:12], new_size[63:38]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], block_index[11:2], blocks_changed[22:12], zero[23]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CAP_BLOCKS = (MAX_BLOCKS < MAX_LIMIT) ? MAX_BLOCKS : MAX_LIMIT;
   localparam int WORDS      = (CAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [COUNT_W-1:0] CAP_LIM = COUNT_W'(CAP_BLOCKS);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_DIV_CUR = 3'd2;
   localparam logic [2:0] S_DIV_NEW = 3'd3;
   localparam logic [2:0] S_PLAN    = 3'd4;
   localparam logic [2:0] S_READ    = 3'd5;
   localparam logic [2:0] S_MODIFY  = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   localparam logic [1:0] M_CREATE = 2'd0;
   localparam logic [1:0] M_CLEAR  = 2'd1;
   localparam logic [1:0] M_CHECK  = 2'd2;
   localparam logic [1:0] M_SET    = 2'd3;

   function automatic logic [BIT_W:0] pop_count(input logic [WORD_BITS-1:0] v);
      logic [BIT_W:0] n;
      n = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         n = n + (BIT_W+1)'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] clamp(input logic [POS_W-1:0] p,
                                              input logic [COUNT_W-1:0] lim);
      return (p >= POS_W'(lim)) ? IDX_W'(lim) : p[IDX_W-1:0];
   endfunction

   // configuration
   logic [BSIZE_W-1:0] block_size_ff;
   logic [COUNT_W-1:0] block_count_ff;
   logic [BSIZE_W-1:0] bs_eff;
   logic [COUNT_W-1:0] limit;

   // control
   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic              rsp_tvalid_ff, rsp_valid_in;

   // working payload
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [START_W-1:0]    start_ff, start_in;
   logic [SIZE_W-1:0]     new_ff, new_in;
   logic [SIZE_W-1:0]     held_ff, held_in;
   logic [SIZE_W-1:0]     want_ff, want_in;
   logic [IDX_W-1:0]      lo_ff, lo_in;
   logic [IDX_W-1:0]      hi_ff, hi_in;
   logic [1:0]            mode_ff, mode_in;
   logic [COUNT_W-1:0]    changed_ff, changed_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [START_W-1:0]    index_ff, index_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_data_in;

   // bitmap memory
   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;

   // divider
   logic              div_start;
   logic [SIZE_W-1:0] div_dividend;
   div_res_type       div_res;

   // plan of the run
   logic [POS_W-1:0] p_start, p_held, p_want;
   logic [IDX_W-1:0] plan_lo, plan_hi;
   logic [1:0]       plan_mode;
   logic             plan_run;
   logic             plan_compact;

   // word view
   logic [IDX_W-1:0]     hm1;
   logic [ADDR_W-1:0]    first_word, last_word;
   logic                 last;
   logic [WORD_BITS-1:0] lo_mask, hi_mask, word_mask, free_bits, used_bits;
   logic [BIT_W-1:0]     free_pos;
   logic [IDX_W-1:0]     found_idx;

   assign bs_eff = (block_size_ff == '0) ? BSIZE_W'(1) : block_size_ff;
   assign limit  = (block_count_ff < CAP_LIM) ? block_count_ff : CAP_LIM;

   cbba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (bs_eff),
      .res      (div_res)
   );

   assign p_start = POS_W'(start_ff);
   assign p_held  = p_start + POS_W'(held_ff);
   assign p_want  = p_start + POS_W'(want_ff);

   always_comb begin
      plan_lo      = '0;
      plan_hi      = '0;
      plan_mode    = M_CLEAR;
      plan_run     = 1'b0;
      plan_compact = 1'b0;
      case (cmd_ff)
         CMD_CREATE: begin
            plan_hi   = IDX_W'(limit);
            plan_mode = M_CREATE;
            plan_run  = 1'b1;
         end
         CMD_DELETE: begin
            plan_lo  = clamp(p_start, limit);
            plan_hi  = clamp(p_held, limit);
            plan_run = 1'b1;
         end
         CMD_TRUNCATE: begin
            if (want_ff <= held_ff) begin
               plan_lo  = clamp(p_want, limit);
               plan_hi  = clamp(p_held, limit);
               plan_run = 1'b1;
            end else if (p_want > POS_W'(limit)) begin
               // free run after the file cannot hold the growth
               plan_compact = 1'b1;
            end else begin
               plan_lo   = p_held[IDX_W-1:0];
               plan_hi   = p_want[IDX_W-1:0];
               plan_mode = M_CHECK;
               plan_run  = 1'b1;
            end
         end
         default: begin
            plan_run = 1'b0;
         end
      endcase
   end

   assign hm1        = hi_ff - IDX_W'(1);
   assign first_word = lo_ff[BIT_W +: ADDR_W];
   assign last_word  = hm1[BIT_W +: ADDR_W];
   assign last       = (waddr_ff == last_word);
   assign lo_mask    = (waddr_ff == first_word) ?
                       ({WORD_BITS{1'b1}} << lo_ff[BIT_W-1:0]) : {WORD_BITS{1'b1}};
   assign hi_mask    = last ?
                       ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hm1[BIT_W-1:0]))
                       : {WORD_BITS{1'b1}};
   assign word_mask  = lo_mask & hi_mask;
   assign free_bits  = ~rd_data_ff & word_mask;
   assign used_bits  = rd_data_ff & word_mask;
   assign free_pos   = lowest_bit(free_bits);
   assign found_idx  = (IDX_W'(waddr_ff) << BIT_W) | IDX_W'(free_pos);

   always_comb begin
      state_in     = state_ff;
      waddr_in     = waddr_ff;
      rsp_valid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in  = rsp_tdata_ff;
      cmd_in       = cmd_ff;
      start_in     = start_ff;
      new_in       = new_ff;
      held_in      = held_ff;
      want_in      = want_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mode_in      = mode_ff;
      changed_in   = changed_ff;
      status_in    = status_ff;
      index_in     = index_ff;
      mem_we       = 1'b0;
      mem_waddr    = waddr_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = waddr_ff;
      div_start    = 1'b0;
      div_dividend = req_tdata[CMD_W+START_W +: SIZE_W];

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            if (waddr_ff == ADDR_W'(WORDS - 1)) begin
               waddr_in = '0;
               state_in = S_IDLE;
            end else begin
               waddr_in = waddr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_tdata[CMD_W-1:0];
               start_in   = req_tdata[CMD_W +: START_W];
               new_in     = req_tdata[CMD_W+START_W+SIZE_W +: SIZE_W];
               changed_in = '0;
               status_in  = RSP_OK;
               index_in   = req_tdata[CMD_W +: START_W];
               if (req_tdata[CMD_W-1:0] == CMD_DELETE ||
                   req_tdata[CMD_W-1:0] == CMD_TRUNCATE) begin
                  div_start = 1'b1;
                  state_in  = S_DIV_CUR;
               end else begin
                  state_in = S_PLAN;
               end
            end
         end
         S_DIV_CUR: begin
            if (div_res.done) begin
               held_in = div_res.blocks;
               if (cmd_ff == CMD_TRUNCATE) begin
                  div_start    = 1'b1;
                  div_dividend = new_ff;
                  state_in     = S_DIV_NEW;
               end else begin
                  state_in = S_PLAN;
               end
            end
         end
         S_DIV_NEW: begin
            if (div_res.done) begin
               want_in  = div_res.blocks;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            if (plan_run && plan_lo < plan_hi) begin
               lo_in    = plan_lo;
               hi_in    = plan_hi;
               mode_in  = plan_mode;
               waddr_in = plan_lo[BIT_W +: ADDR_W];
               state_in = S_READ;
            end else begin
               if (plan_compact) status_in = RSP_COMPACT;
               if (cmd_ff == CMD_CREATE) begin
                  status_in = RSP_NO_FREE;
                  index_in  = '0;
               end
               state_in = S_DONE;
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            case (mode_ff)
               M_CREATE: begin
                  if (free_bits != '0) begin
                     mem_we     = 1'b1;
                     mem_wdata  = rd_data_ff | (WORD_BITS'(1) << free_pos);
                     index_in   = found_idx[START_W-1:0];
                     changed_in = COUNT_W'(1);
                     state_in   = S_DONE;
                  end else if (last) begin
                     status_in = RSP_NO_FREE;
                     index_in  = '0;
                     state_in  = S_DONE;
                  end else begin
                     waddr_in = waddr_ff + ADDR_W'(1);
                     state_in = S_READ;
                  end
               end
               M_CLEAR: begin
                  mem_we     = 1'b1;
                  mem_wdata  = rd_data_ff & ~word_mask;
                  changed_in = changed_ff + COUNT_W'(pop_count(used_bits));
                  if (last) begin
                     state_in = S_DONE;
                  end else begin
                     waddr_in = waddr_ff + ADDR_W'(1);
                     state_in = S_READ;
                  end
               end
               M_CHECK: begin
                  if (used_bits != '0) begin
                     status_in = RSP_COMPACT;
                     state_in  = S_DONE;
                  end else if (last) begin
                     // run is free, go over the same words again and claim them
                     mode_in  = M_SET;
                     waddr_in = first_word;
                     state_in = S_READ;
                  end else begin
                     waddr_in = waddr_ff + ADDR_W'(1);
                     state_in = S_READ;
                  end
               end
               default: begin
                  mem_we     = 1'b1;
                  mem_wdata  = rd_data_ff | word_mask;
                  changed_in = changed_ff + COUNT_W'(pop_count(free_bits));
                  if (last) begin
                     state_in = S_DONE;
                  end else begin
                     waddr_in = waddr_ff + ADDR_W'(1);
                     state_in = S_READ;
                  end
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, changed_ff, index_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         waddr_ff       <= '0;
         rsp_tvalid_ff  <= 1'b0;
         block_size_ff  <= BSIZE_W'(64);
         block_count_ff <= COUNT_W'(1024);
      end else begin
         state_ff      <= state_in;
         waddr_ff      <= waddr_in;
         rsp_tvalid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_BLOCK_SIZE:  block_size_ff  <= csr_wdata;
               CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      start_ff     <= start_in;
      new_ff       <= new_in;
      held_ff      <= held_in;
      want_ff      <= want_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mode_ff      <= mode_in;
      changed_ff   <= changed_in;
      status_ff    <= status_in;
      index_ff     <= index_in;
      rsp_tdata_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   a_no_free_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[STATUS_W-1:0] == RSP_NO_FREE
      |-> rsp_tdata[STATUS_W+START_W +: COUNT_W] == '0 &&
          rsp_tdata[STATUS_W +: START_W] == '0)
      else $error("failed create reports a change or an index");
   a_compact_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[STATUS_W-1:0] == RSP_COMPACT
      |-> rsp_tdata[STATUS_W+START_W +: COUNT_W] == '0)
      else $error("compaction answer with changed blocks");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != S_IDLE)
      else $error("request taken but sequencer stayed idle");
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> mem_waddr <= ADDR_W'(WORDS - 1))
      else $error("bitmap write beyond the last word");
   a_read_before_modify: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MODIFY |-> $past(mem_re))
      else $error("word modified without a read");
`endif

endmodule

>>> sv/cbba_div.sv
// iterative divider that turns a byte size into a block count, one quotient bit per cycle
module cbba_div
   import cbba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SIZE_W-1:0]  dividend,
   input  logic [BSIZE_W-1:0] divisor,
   output div_res_type        res
);

   localparam int CNT_W = $clog2(SIZE_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               zero_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [SIZE_W-1:0]  quo_ff;
   logic [BSIZE_W-1:0] rem_ff;
   logic [BSIZE_W-1:0] dsr_ff;

   logic [BSIZE_W:0]   shifted;
   logic [BSIZE_W:0]   trial;
   logic               fits;

   assign shifted = {rem_ff, quo_ff[SIZE_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == CNT_W'(SIZE_W - 1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
         cnt_ff  <= '0;
         zero_ff <= (dividend == '0);
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SIZE_W-2:0], fits};
         rem_ff <= fits ? trial[BSIZE_W-1:0] : shifted[BSIZE_W-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // ceiling of the quotient, an empty file still holds one block
   assign res.done   = done_ff;
   assign res.blocks = zero_ff ? SIZE_W'(1) : (quo_ff + SIZE_W'(rem_ff != '0));

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_no_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff || $past(start))
      else $error("divider still busy after finishing");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= CNT_W'(SIZE_W - 1))
      else $error("divider step count out of range");
`endif

endmodule
